// ===== hw/rtl/snn_pkg.sv =====
// Shared types and constants for the sparse network evaluator.
// Holds the sigmoid table function used by the core; no dependencies.
package snn_pkg;
    localparam int MAX_NEURONS = 64;
    localparam int MAX_CONNECTIONS = 256;
    localparam int SIG_DEPTH = 1024;
    localparam int NW = $clog2(MAX_NEURONS);
    localparam int CW = $clog2(MAX_CONNECTIONS);
    localparam int SW = $clog2(SIG_DEPTH);

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_LINK  = 2'd1;
    localparam logic [1:0] OP_VALUE = 2'd2;
    localparam logic [1:0] OP_RUN   = 2'd3;

    localparam logic [1:0] REG_INPUTS  = 2'd0;
    localparam logic [1:0] REG_OUTPUTS = 2'd1;
    localparam logic [1:0] REG_NEURONS = 2'd2;
    localparam logic [1:0] REG_LINKS   = 2'd3;

    localparam logic signed [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
    localparam logic signed [39:0] SUM_MIN = {1'b1, {39{1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_FETCH = 7'b0000100,
        ST_MAC   = 7'b0001000,
        ST_SQ    = 7'b0010000,
        ST_CHECK = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    // Restoring long division, used only while the constant table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Evaluated only at elaboration to fill a constant table.
    function automatic logic [63:0] exp_neg_q32(input logic [63:0] a);
        logic [63:0] k, f, pos, neg, term, e;
        k = a >> 32;
        f = a & 64'hFFFF_FFFF;
        pos = 64'd1 << 32;
        neg = 0;
        term = 64'd1 << 32;
        for (int n = 1; n <= 16; n++) begin
            term = udiv64((term * f) >> 32, 64'(n));
            if ((n & 1) == 1) neg = neg + term;
            else pos = pos + term;
        end
        e = (pos > neg) ? pos - neg : 64'd0;
        for (int j = 0; j < 16; j++) begin
            if (64'(j) < k) e = (e * 64'd1580030169) >> 32;
        end
        return e;
    endfunction

    function automatic logic [12:0] sig_entry(input int i);
        logic [63:0] mid, e, den, twelve;
        twelve = 64'd12 << 32;
        mid = ((64'd24 * 64'(2 * i + 1)) << 32) >> (SW + 1);
        if (mid >= twelve) begin
            e = exp_neg_q32(mid - twelve);
            den = (64'd1 << 32) + e;
            return 13'(udiv64((64'd1 << 45) + den, den << 1));
        end
        e = exp_neg_q32(twelve - mid);
        den = (64'd1 << 32) + e;
        return 13'(udiv64((e << 13) + den, den << 1));
    endfunction

    typedef logic [12:0] t_sig_rom [SIG_DEPTH];
    function automatic t_sig_rom build_sig();
        t_sig_rom t;
        for (int i = 0; i < SIG_DEPTH; i++) t[i] = sig_entry(i);
        return t;
    endfunction
    localparam t_sig_rom SIG_ROM = build_sig();
endpackage

// ===== hw/rtl/sparse_neural_net_evaluator_core.sv =====
// Sparse recurrent network evaluator top level; depends on snn_pkg and snn_mac.
// Load items finish without leaving idle; a clear sweeps all 64 neuron slots. A run pass
// walks every connection, skipping unusable ones, then squashes each non-input neuron;
// a settling run repeats up to N passes. Results then follow and cannot be stalled.
// Synchronous active-low reset empties neuron state through a clearing pass over all 64
// neurons with busy high; the connection table is undefined until written.
module sparse_neural_net_evaluator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_slot,
    input  logic [5:0]  i_source_neuron,
    input  logic [5:0]  i_target_neuron,
    input  logic signed [15:0] i_link_weight,
    input  logic signed [15:0] i_input_value,
    output logic        o_valid,
    output logic [4:0]  o_output_number,
    output logic [12:0] o_output_activation,
    output logic        o_last
);
    import snn_pkg::*;

    t_state r_state;
    logic [5:0] r_nin_cfg, r_nout_cfg;
    logic [6:0] r_nn_cfg;
    logic [8:0] r_nc_cfg;
    logic [6:0] w_n, w_nin, w_nout;
    logic [8:0] w_nc;

    logic signed [15:0] r_act [MAX_NEURONS];
    logic signed [39:0] r_sum [MAX_NEURONS];
    logic [MAX_NEURONS-1:0] r_active;
    logic r_settled;
    logic [27:0] r_link [MAX_CONNECTIONS];
    logic [27:0] r_lrd;
    logic signed [15:0] r_act_rd;
    logic signed [39:0] r_sum_rd;

    logic [8:0] r_ci;
    logic [6:0] r_ni, r_pass;
    logic r_settling, r_allact;
    logic [5:0] r_tgt;
    logic [1:0] r_phase;
    logic r_init;
    logic signed [39:0] w_mac;
    logic [6:0] w_ea;

    always_comb begin
        w_n = (r_nn_cfg > 7'(MAX_NEURONS)) ? 7'(MAX_NEURONS) : r_nn_cfg;
        w_nin = ({1'b0, r_nin_cfg} < w_n) ? {1'b0, r_nin_cfg} : w_n;
        w_nout = ({1'b0, r_nout_cfg} < (w_n - w_nin)) ? {1'b0, r_nout_cfg} : (w_n - w_nin);
        if (w_nout > 7'd32) w_nout = 7'd32;
        w_nc = (r_nc_cfg > 9'(MAX_CONNECTIONS)) ? 9'(MAX_CONNECTIONS) : r_nc_cfg;
    end

    assign busy = (r_state != ST_IDLE);
    assign w_ea = w_nin + r_ni;

    // Connection table read: source[27:22] target[21:16] weight[15:0].
    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_state == ST_IDLE && start && i_operation == OP_LINK)
            r_link[i_slot[CW-1:0]] <= {i_source_neuron, i_target_neuron, i_link_weight};
        r_lrd <= r_link[r_ci[CW-1:0]];
    end

    logic [5:0] w_src, w_dst;
    logic signed [15:0] w_wt;
    assign w_src = r_lrd[27:22];
    assign w_dst = r_lrd[21:16];
    assign w_wt = r_lrd[15:0];

    snn_mac u_mac (
        .i_clk(i_clk), .i_act(r_act_rd), .i_weight(w_wt),
        .i_sum(r_sum_rd), .o_sum(w_mac)
    );

    logic signed [39:0] w_s;
    logic [SW-1:0] w_idx;
    logic [40:0] w_off;
    logic signed [15:0] w_oa;
    always_comb begin
        w_s = r_sum_rd;
        w_off = 41'(w_s) + 41'(64'sd1 <<< 26);
        if (w_s < -(40'sd1 <<< 26)) w_idx = '0;
        else if (w_s >= (40'sd1 <<< 26)) w_idx = SW'(SIG_DEPTH - 1);
        else w_idx = w_off[26 -: SW];
        w_oa = r_act_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_nin_cfg <= 6'd2; r_nout_cfg <= 6'd1; r_nn_cfg <= 7'd3; r_nc_cfg <= 9'd0;
            r_active <= '0; r_settled <= 1'b0; o_valid <= 1'b0;
            r_ni <= '0; r_ci <= '0; r_pass <= '0; r_phase <= '0;
            r_init <= 1'b1;
        end else begin
            o_valid <= (r_state == ST_EMIT) && (r_phase == 2'd1);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_INPUTS:  r_nin_cfg <= i_cfg_data[5:0];
                    REG_OUTPUTS: r_nout_cfg <= i_cfg_data[5:0];
                    REG_NEURONS: r_nn_cfg <= i_cfg_data[6:0];
                    REG_LINKS:   r_nc_cfg <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: if (start) begin
                    case (i_operation)
                        OP_CLEAR: begin
                            r_ni <= '0; r_settled <= 1'b0; r_state <= ST_CLEAR;
                        end
                        OP_VALUE: if ({1'b0, i_slot} < {2'b0, w_nin})
                            r_act[i_slot[NW-1:0]] <= i_input_value;
                        OP_RUN: begin
                            r_settling <= !r_settled; r_settled <= 1'b1;
                            r_pass <= '0; r_ci <= '0;
                            r_state <= ST_FETCH;
                        end
                        default: ;
                    endcase
                end
                ST_CLEAR: begin
                    // The pass after reset leaves every neuron inactive.
                    r_act[r_ni[NW-1:0]] <= '0; r_sum[r_ni[NW-1:0]] <= '0;
                    r_active[r_ni[NW-1:0]] <= !r_init && (r_ni < w_nin);
                    r_ni <= r_ni + 7'd1;
                    if (r_ni == 7'(MAX_NEURONS - 1)) begin
                        r_init <= 1'b0; r_state <= ST_IDLE;
                    end
                end
                ST_FETCH: begin
                    // Table read registers this cycle; the MAC follows.
                    r_phase <= '0;
                    if (r_ci == w_nc) begin
                        r_ni <= w_nin; r_allact <= 1'b1; r_state <= ST_SQ;
                    end else begin
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (r_phase == 2'd0) begin
                        if ({1'b0, w_src} >= w_n || {1'b0, w_dst} >= w_n ||
                            (r_settling && !r_active[w_src])) begin
                            r_ci <= r_ci + 9'd1; r_state <= ST_FETCH;
                        end else begin
                            if (r_settling) r_active[w_dst] <= 1'b1;
                            r_tgt <= w_dst;
                            r_act_rd <= r_act[w_src];
                            r_sum_rd <= r_sum[w_dst];
                            r_phase <= 2'd1;
                        end
                    end else if (r_phase == 2'd1) begin
                        // The MAC registers the saturated sum this cycle.
                        r_phase <= 2'd2;
                    end else begin
                        r_sum[r_tgt] <= w_mac;
                        r_ci <= r_ci + 9'd1; r_state <= ST_FETCH;
                    end
                end
                ST_SQ: begin
                    if (r_phase == 2'd0) begin
                        if (r_ni == w_n) r_state <= ST_CHECK;
                        else begin
                            r_sum_rd <= r_sum[r_ni[NW-1:0]];
                            r_phase <= 2'd1;
                        end
                    end else begin
                        if (!r_settling || r_active[r_ni[NW-1:0]]) begin
                            r_act[r_ni[NW-1:0]] <= 16'(SIG_ROM[w_idx]);
                            r_sum[r_ni[NW-1:0]] <= '0;
                        end else r_allact <= 1'b0;
                        r_ni <= r_ni + 7'd1;
                        r_phase <= 2'd0;
                    end
                end
                ST_CHECK: begin
                    if (r_settling && !r_allact && (r_pass + 7'd1) < w_n) begin
                        r_pass <= r_pass + 7'd1; r_ci <= '0; r_state <= ST_FETCH;
                    end else begin
                        r_ni <= '0; r_phase <= '0; r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_phase == 2'd0) begin
                        if (r_ni == w_nout) r_state <= ST_IDLE;
                        else begin
                            r_act_rd <= r_act[w_ea[NW-1:0]];
                            r_phase <= 2'd1;
                        end
                    end else begin
                        o_output_number <= r_ni[4:0];
                        o_output_activation <= w_oa[15] ? 13'd0 :
                            (w_oa > 16'sd4096) ? 13'd4096 : w_oa[12:0];
                        o_last <= (r_ni + 7'd1 == w_nout);
                        r_ni <= r_ni + 7'd1;
                        r_phase <= 2'd0;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/snn_mac.sv =====
// Shared multiply-accumulate unit with 40-bit saturation, one register stage.
// Depends on snn_pkg.
module snn_mac (
    input  logic                i_clk,
    input  logic signed [15:0]  i_act,
    input  logic signed [15:0]  i_weight,
    input  logic signed [39:0]  i_sum,
    output logic signed [39:0]  o_sum
);
    import snn_pkg::*;
    logic signed [31:0] w_prod;
    logic signed [40:0] w_add;
    logic signed [39:0] r_sum;
    assign w_prod = i_act * i_weight;
    assign w_add = 41'(i_sum) + 41'(w_prod);
    always_ff @(posedge i_clk) begin
        if (w_add > 41'(SUM_MAX)) r_sum <= SUM_MAX;
        else if (w_add < 41'(SUM_MIN)) r_sum <= SUM_MIN;
        else r_sum <= w_add[39:0];
    end
    assign o_sum = r_sum;
endmodule
